// ===== rtl/gbn_pkg.sv =====
// Shared types and constants for the go-back-n window controller.
// No dependencies; imported by gbn_ctrl, gbn_datapath and the top level.
package gbn_pkg;

    localparam int SEQ_W   = 3;
    localparam int SEQ_MOD = 1 << SEQ_W;
    localparam int SEQ_MAX = SEQ_MOD - 1;
    localparam int PKT_W   = 32;
    localparam int LEN_W   = 10;
    localparam int WALK_W  = SEQ_W + 1;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN  = LEN_W'(5);
    localparam logic [LEN_W-1:0] FRAME_OVERHEAD = LEN_W'(6);

    typedef enum logic [1:0] {
        OP_NET_READY  = 2'd0,
        OP_PHY_READY  = 2'd1,
        OP_FRAME_RECV = 2'd2,
        OP_TIMEOUT    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_STATUS  = 2'd3
    } result_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic send_new;
        logic set_link;
        logic deliver;
        logic rewind;
        logic ack_step;
        logic resend_step;
        logic emit_status;
    } gbn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t op;
        logic    space;
        logic    frame_ok;
        logic    in_order;
        logic    walk_go;
        logic    out_free;
    } gbn_sts_t;

endpackage

// ===== rtl/gbn_ctrl.sv =====
// Event sequencer for the go-back-n window controller.
// Depends on gbn_pkg; drives gbn_datapath through gbn_cmd_t.
module gbn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gbn_pkg::gbn_sts_t sts,
    output gbn_pkg::gbn_cmd_t cmd
);
    import gbn_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_STATUS = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (sts.out_free) begin
                    case (sts.op)
                        OP_NET_READY: begin
                            cmd.send_new = sts.space;
                            state_next   = ST_STATUS;
                        end
                        OP_PHY_READY: begin
                            cmd.set_link = 1'b1;
                            state_next   = ST_STATUS;
                        end
                        OP_FRAME_RECV: begin
                            cmd.deliver = sts.frame_ok && sts.in_order;
                            state_next  = sts.frame_ok ? ST_WALK : ST_STATUS;
                        end
                        OP_TIMEOUT: begin
                            cmd.rewind = 1'b1;
                            state_next = ST_WALK;
                        end
                        default: state_next = ST_STATUS;
                    endcase
                end
            end
            ST_WALK: begin
                if (sts.out_free) begin
                    if (!sts.walk_go) begin
                        state_next = ST_STATUS;
                    end else if (sts.op == OP_TIMEOUT) begin
                        cmd.resend_step = 1'b1;
                    end else begin
                        cmd.ack_step = 1'b1;
                    end
                end
            end
            ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/gbn_datapath.sv =====
// Window state, descriptor slots and result register of the controller.
// Depends on gbn_pkg; commanded by gbn_ctrl.
module gbn_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [1:0]                  s_opcode,
    input  logic [gbn_pkg::PKT_W-1:0]   s_packet_word,
    input  logic [gbn_pkg::SEQ_W-1:0]   s_frame_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]   s_frame_ack,
    input  logic [gbn_pkg::LEN_W-1:0]   s_frame_len,
    input  logic                        s_crc_good,
    input  gbn_pkg::gbn_cmd_t           cmd,
    output gbn_pkg::gbn_sts_t           sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_result_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   m_result_seq,
    output logic [gbn_pkg::SEQ_W-1:0]   m_result_ack,
    output logic [gbn_pkg::PKT_W-1:0]   m_result_packet,
    output logic [gbn_pkg::LEN_W-1:0]   m_deliver_len,
    output logic                        m_network_enable,
    output logic                        m_last
);
    import gbn_pkg::*;

    // latched transaction
    opcode_t            op_reg;
    logic [PKT_W-1:0]   pkt_reg;
    logic [SEQ_W-1:0]   fseq_reg, fack_reg;
    logic [LEN_W-1:0]   flen_reg;
    logic               crc_reg;

    // window state
    logic [SEQ_W-1:0]   ack_lower_reg, ack_lower_next;
    logic [SEQ_W-1:0]   nts_reg, nts_next;
    logic [SEQ_W-1:0]   recv_exp_reg, recv_exp_next;
    logic [SEQ_W-1:0]   count_reg, count_next;
    logic               link_reg, link_next;
    logic [WALK_W-1:0]  walk_reg, walk_next;
    logic [PKT_W-1:0]   slot_reg [SEQ_MOD];

    // result register
    logic               out_valid_reg, out_valid_next;
    result_kind_t       kind_reg, kind_next;
    logic [SEQ_W-1:0]   rseq_reg, rseq_next;
    logic [SEQ_W-1:0]   rack_reg, rack_next;
    logic [PKT_W-1:0]   rpkt_reg, rpkt_next;
    logic [LEN_W-1:0]   dlen_reg, dlen_next;
    logic               en_reg, en_next;
    logic               last_reg, last_next;

    logic               space, ack_in_win, emit;
    logic [SEQ_W-1:0]   send_ack;
    logic [LEN_W-1:0]   payload_len;

    assign space       = (count_reg < SEQ_W'(SEQ_MAX));
    assign send_ack    = recv_exp_reg - SEQ_W'(1);
    assign payload_len = (flen_reg > FRAME_OVERHEAD) ? (flen_reg - FRAME_OVERHEAD) : '0;
    assign ack_in_win  = ((ack_lower_reg <= fack_reg) && (fack_reg < nts_reg))
                      || ((nts_reg < ack_lower_reg) && (ack_lower_reg <= fack_reg))
                      || ((fack_reg < nts_reg) && (nts_reg < ack_lower_reg));

    assign sts.op       = op_reg;
    assign sts.space    = space;
    assign sts.frame_ok = (flen_reg >= MIN_FRAME_LEN) && crc_reg;
    assign sts.in_order = (fseq_reg == recv_exp_reg);
    assign sts.walk_go  = (walk_reg != '0) && ((op_reg == OP_TIMEOUT) || ack_in_win);
    assign sts.out_free = !out_valid_reg || m_ready;

    assign emit = cmd.send_new || cmd.deliver || cmd.ack_step
               || cmd.resend_step || cmd.emit_status;

    always_comb begin
        ack_lower_next = ack_lower_reg;
        nts_next       = nts_reg;
        recv_exp_next  = recv_exp_reg;
        count_next     = count_reg;
        link_next      = link_reg;
        walk_next      = walk_reg;
        kind_next      = KIND_STATUS;
        rseq_next      = '0;
        rack_next      = '0;
        rpkt_next      = '0;
        dlen_next      = '0;
        en_next        = 1'b0;
        last_next      = 1'b0;
        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

        if (cmd.send_new) begin
            kind_next  = KIND_SEND;
            rseq_next  = nts_reg;
            rack_next  = send_ack;
            rpkt_next  = pkt_reg;
            count_next = count_reg + SEQ_W'(1);
            nts_next   = nts_reg + SEQ_W'(1);
            link_next  = 1'b0;
        end
        if (cmd.set_link) begin
            link_next = 1'b1;
        end
        if (cmd.deliver) begin
            kind_next     = KIND_DELIVER;
            rpkt_next     = pkt_reg;
            dlen_next     = payload_len;
            recv_exp_next = recv_exp_reg + SEQ_W'(1);
        end
        if (cmd.deliver || (op_reg == OP_FRAME_RECV && cmd.load_in == 1'b0 && cmd.rewind == 1'b0
                            && cmd.ack_step == 1'b0 && cmd.resend_step == 1'b0
                            && cmd.emit_status == 1'b0)) begin
            walk_next = WALK_W'(SEQ_MOD);
        end
        if (cmd.rewind) begin
            nts_next  = ack_lower_reg;
            walk_next = WALK_W'(count_reg);
        end
        if (cmd.ack_step) begin
            kind_next      = KIND_STOP;
            rseq_next      = ack_lower_reg;
            ack_lower_next = ack_lower_reg + SEQ_W'(1);
            count_next     = (count_reg != '0) ? count_reg - SEQ_W'(1) : '0;
            walk_next      = walk_reg - WALK_W'(1);
        end
        if (cmd.resend_step) begin
            kind_next = KIND_SEND;
            rseq_next = nts_reg;
            rack_next = send_ack;
            rpkt_next = slot_reg[nts_reg];
            nts_next  = nts_reg + SEQ_W'(1);
            link_next = 1'b0;
            walk_next = walk_reg - WALK_W'(1);
        end
        if (cmd.emit_status) begin
            kind_next = KIND_STATUS;
            en_next   = space && link_reg;
            last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_lower_reg <= '0;
            nts_reg       <= '0;
            recv_exp_reg  <= '0;
            count_reg     <= '0;
            link_reg      <= 1'b0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ack_lower_reg <= ack_lower_next;
            nts_reg       <= nts_next;
            recv_exp_reg  <= recv_exp_next;
            count_reg     <= count_next;
            link_reg      <= link_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= opcode_t'(s_opcode);
            pkt_reg  <= s_packet_word;
            fseq_reg <= s_frame_seq;
            fack_reg <= s_frame_ack;
            flen_reg <= s_frame_len;
            crc_reg  <= s_crc_good;
        end
        if (cmd.send_new) begin
            slot_reg[nts_reg] <= pkt_reg;
        end
        if (emit) begin
            kind_reg <= kind_next;
            rseq_reg <= rseq_next;
            rack_reg <= rack_next;
            rpkt_reg <= rpkt_next;
            dlen_reg <= dlen_next;
            en_reg   <= en_next;
            last_reg <= last_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_result_seq     = rseq_reg;
    assign m_result_ack     = rack_reg;
    assign m_result_packet  = rpkt_reg;
    assign m_deliver_len    = dlen_reg;
    assign m_network_enable = en_reg;
    assign m_last           = last_reg;

endmodule

// ===== rtl/go_back_n_window_control.sv =====
// Go-back-n sliding-window controller, 3-bit sequence numbers.
// From acceptance to its status transaction, an event is latched, then walks the window if it is
// a good frame or a timeout (ack or resend walk, one slot a cycle while m_ready does not stall it),
// then leaves the walk and emits its status; m_ready can stall the result register at each result.
// One event at a time; s_ready is high only between events.
// Synchronous active-low reset clears window state; descriptor slots are not cleared.
module go_back_n_window_control (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [gbn_pkg::PKT_W-1:0]   s_packet_word,
    input  logic [gbn_pkg::SEQ_W-1:0]   s_frame_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]   s_frame_ack,
    input  logic [gbn_pkg::LEN_W-1:0]   s_frame_len,
    input  logic                        s_crc_good,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_result_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   m_result_seq,
    output logic [gbn_pkg::SEQ_W-1:0]   m_result_ack,
    output logic [gbn_pkg::PKT_W-1:0]   m_result_packet,
    output logic [gbn_pkg::LEN_W-1:0]   m_deliver_len,
    output logic                        m_network_enable,
    output logic                        m_last
);
    import gbn_pkg::*;

    gbn_cmd_t cmd;
    gbn_sts_t sts;

    gbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gbn_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_opcode         (s_opcode),
        .s_packet_word    (s_packet_word),
        .s_frame_seq      (s_frame_seq),
        .s_frame_ack      (s_frame_ack),
        .s_frame_len      (s_frame_len),
        .s_crc_good       (s_crc_good),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_result_seq     (m_result_seq),
        .m_result_ack     (m_result_ack),
        .m_result_packet  (m_result_packet),
        .m_deliver_len    (m_deliver_len),
        .m_network_enable (m_network_enable),
        .m_last           (m_last)
    );

endmodule

// ===== verif/go_back_n_window_control_tb.sv =====
// Self-checking testbench for go_back_n_window_control: directed and random link events,
// each result checked against an in-bench model of the sliding window.
// Depends on gbn_pkg and the go_back_n_window_control RTL.
`timescale 1ns / 100ps

module go_back_n_window_control_tb;
    import gbn_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 250;
    localparam int PHASE_EVENTS   = 48;

    typedef struct {
        opcode_t            op;
        logic [PKT_W-1:0]   pkt;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   ack;
        logic [LEN_W-1:0]   len;
        logic               crc;
        bit                 drain;
    } link_event_t;

    typedef struct {
        result_kind_t       kind;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   ack;
        logic [PKT_W-1:0]   pkt;
        logic [LEN_W-1:0]   dlen;
        logic               en;
        logic               last;
    } link_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = '0;
    logic [PKT_W-1:0]   s_packet_word = '0;
    logic [SEQ_W-1:0]   s_frame_seq = '0;
    logic [SEQ_W-1:0]   s_frame_ack = '0;
    logic [LEN_W-1:0]   s_frame_len = '0;
    logic               s_crc_good = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_result_kind;
    logic [SEQ_W-1:0]   m_result_seq;
    logic [SEQ_W-1:0]   m_result_ack;
    logic [PKT_W-1:0]   m_result_packet;
    logic [LEN_W-1:0]   m_deliver_len;
    logic               m_network_enable;
    logic               m_last;

    go_back_n_window_control DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_packet_word    (s_packet_word),
        .s_frame_seq      (s_frame_seq),
        .s_frame_ack      (s_frame_ack),
        .s_frame_len      (s_frame_len),
        .s_crc_good       (s_crc_good),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_result_seq     (m_result_seq),
        .m_result_ack     (m_result_ack),
        .m_result_packet  (m_result_packet),
        .m_deliver_len    (m_deliver_len),
        .m_network_enable (m_network_enable),
        .m_last           (m_last)
    );

    always #5 aclk = ~aclk;

    link_event_t    link_event_q[$];
    link_result_t   due_results[$];
    link_event_t    on_wire;
    link_result_t   want;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int events_taken = 0;
    int results_seen = 0;
    int sends_seen = 0;
    int deliveries_seen = 0;
    int stops_seen = 0;
    int full_drops = 0;

    // window model, updated on each accepted event
    logic [SEQ_W-1:0] win_base = '0;
    logic [SEQ_W-1:0] next_seq = '0;
    logic [SEQ_W-1:0] rx_expect = '0;
    int               in_flight = 0;
    logic             link_up = 1'b0;
    logic [PKT_W-1:0] desc_store [SEQ_MOD];

    // stimulus-side view of the window, used to aim seq and ack fields
    logic [SEQ_W-1:0] gen_base = '0;
    logic [SEQ_W-1:0] gen_next = '0;
    logic [SEQ_W-1:0] gen_rx = '0;
    int               gen_cnt = 0;

    function automatic bit acked(logic [SEQ_W-1:0] lo, logic [SEQ_W-1:0] ack,
                                 logic [SEQ_W-1:0] hi);
        return SEQ_W'(ack - lo) < SEQ_W'(hi - lo);
    endfunction

    task automatic push_result(result_kind_t kind, logic [SEQ_W-1:0] seq,
                               logic [SEQ_W-1:0] ack, logic [PKT_W-1:0] pkt,
                               logic [LEN_W-1:0] dlen, logic en, logic last);
        link_result_t r;
        r = '{kind, seq, ack, pkt, dlen, en, last};
        due_results.push_back(r);
    endtask

    task automatic predict_send(logic [SEQ_W-1:0] seq);
        push_result(KIND_SEND, seq, SEQ_W'(rx_expect - 1'b1), desc_store[seq], '0, 1'b0,
                    1'b0);
        link_up = 1'b0;
    endtask

    task automatic run_arq_event(input link_event_t ev);
        int k;
        case (ev.op)
            OP_NET_READY: begin
                if (in_flight < SEQ_MAX) begin
                    in_flight++;
                    desc_store[next_seq] = ev.pkt;
                    predict_send(next_seq);
                    next_seq++;
                end else begin
                    full_drops++;
                end
            end
            OP_PHY_READY: link_up = 1'b1;
            OP_FRAME_RECV: begin
                if (ev.len >= MIN_FRAME_LEN && ev.crc) begin
                    if (ev.seq == rx_expect) begin
                        push_result(KIND_DELIVER, '0, '0, ev.pkt,
                                    (ev.len > FRAME_OVERHEAD) ? LEN_W'(ev.len - FRAME_OVERHEAD)
                                                              : '0,
                                    1'b0, 1'b0);
                        rx_expect++;
                    end
                    for (k = 0; k < SEQ_MOD && acked(win_base, ev.ack, next_seq); k++) begin
                        if (in_flight > 0) in_flight--;
                        push_result(KIND_STOP, win_base, '0, '0, '0, 1'b0, 1'b0);
                        win_base++;
                    end
                end
            end
            default: begin
                next_seq = win_base;
                for (k = 0; k < in_flight; k++) begin
                    predict_send(next_seq);
                    next_seq++;
                end
            end
        endcase
        push_result(KIND_STATUS, '0, '0, '0, '0, (in_flight < SEQ_MAX) && link_up, 1'b1);
    endtask

    task automatic queue_event(opcode_t op, logic [PKT_W-1:0] pkt, logic [SEQ_W-1:0] seq,
                               logic [SEQ_W-1:0] ack, logic [LEN_W-1:0] len, logic crc,
                               bit drain);
        link_event_t ev;
        ev = '{op, pkt, seq, ack, len, crc, drain};
        link_event_q.push_back(ev);
        case (op)
            OP_NET_READY: begin
                if (gen_cnt < SEQ_MAX) begin
                    gen_cnt++;
                    gen_next++;
                end
            end
            OP_FRAME_RECV: begin
                if (len >= MIN_FRAME_LEN && crc) begin
                    if (seq == gen_rx) gen_rx++;
                    while (acked(gen_base, ack, gen_next)) begin
                        gen_base++;
                        gen_cnt--;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_random_event();
        int pick;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        logic [LEN_W-1:0] len;
        bit drain;
        pick = $urandom_range(99);
        drain = ($urandom_range(99) < 4);
        seq = ($urandom_range(99) < 75) ? gen_rx : SEQ_W'($urandom);
        if (gen_cnt > 0 && $urandom_range(99) < 70)
            ack = gen_base + SEQ_W'($urandom_range(gen_cnt - 1));
        else
            ack = SEQ_W'($urandom);
        len = ($urandom_range(99) < 10) ? LEN_W'($urandom_range(6))
                                        : LEN_W'($urandom_range(1023, 7));
        if (pick < 10)
            queue_event(opcode_t'($urandom_range(3)), $urandom, SEQ_W'($urandom),
                        SEQ_W'($urandom), LEN_W'($urandom), 1'($urandom), drain);
        else if (pick < 40)
            queue_event(OP_NET_READY, $urandom, SEQ_W'($urandom), SEQ_W'($urandom),
                        LEN_W'($urandom), 1'($urandom), drain);
        else if (pick < 50)
            queue_event(OP_PHY_READY, $urandom, SEQ_W'($urandom), SEQ_W'($urandom),
                        LEN_W'($urandom), 1'($urandom), drain);
        else if (pick < 88)
            queue_event(OP_FRAME_RECV, $urandom, seq, ack, len, $urandom_range(99) < 90,
                        drain);
        else
            queue_event(OP_TIMEOUT, $urandom, SEQ_W'($urandom), SEQ_W'($urandom),
                        LEN_W'($urandom), 1'($urandom), drain);
    endtask

    task automatic report_mismatch(string what, logic [PKT_W-1:0] got,
                                   logic [PKT_W-1:0] exp_val);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                run_arq_event(on_wire);
                events_taken++;
            end
            if (!s_valid || s_ready) begin
                if (link_event_q.size() > 0 && $urandom_range(99) >= sender_idle_pct
                    && !(link_event_q[0].drain && due_results.size() > 0)) begin
                    on_wire = link_event_q.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= on_wire.op;
                    s_packet_word <= on_wire.pkt;
                    s_frame_seq   <= on_wire.seq;
                    s_frame_ack   <= on_wire.ack;
                    s_frame_len   <= on_wire.len;
                    s_crc_good    <= on_wire.crc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("transaction with nothing due (kind)", m_result_kind, '0);
            end else begin
                want = due_results.pop_front();
                case (want.kind)
                    KIND_SEND:    sends_seen++;
                    KIND_DELIVER: deliveries_seen++;
                    KIND_STOP:    stops_seen++;
                    default: ;
                endcase
                if (m_result_kind !== want.kind)
                    report_mismatch("result_kind", m_result_kind, want.kind);
                if (m_result_seq !== want.seq)
                    report_mismatch("result_seq", m_result_seq, want.seq);
                if (m_result_ack !== want.ack)
                    report_mismatch("result_ack", m_result_ack, want.ack);
                if (m_result_packet !== want.pkt)
                    report_mismatch("result_packet", m_result_packet, want.pkt);
                if (m_deliver_len !== want.dlen)
                    report_mismatch("deliver_len", m_deliver_len, want.dlen);
                if (m_network_enable !== want.en)
                    report_mismatch("network_enable", m_network_enable, want.en);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, due_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        queue_event(OP_TIMEOUT, '0, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_FRAME_RECV, 32'h1234_5678, 3'd0, 3'd0, 10'd1023, 1'b0, 1'b0);
        queue_event(OP_NET_READY, 32'h0000_0000, 3'd7, 3'd7, 10'd0, 1'b1, 1'b0);
        queue_event(OP_PHY_READY, '0, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_NET_READY, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_FRAME_RECV, 32'hA5A5_A5A5, 3'd0, 3'd0, 10'd4, 1'b1, 1'b0);
        queue_event(OP_FRAME_RECV, 32'h5A5A_5A5A, 3'd0, 3'd5, 10'd5, 1'b1, 1'b0);
        queue_event(OP_FRAME_RECV, 32'hDEAD_0001, 3'd3, 3'd0, 10'd6, 1'b1, 1'b0);
        queue_event(OP_FRAME_RECV, 32'hFFFF_FFFF, 3'd1, 3'd1, 10'd1023, 1'b1, 1'b0);
        queue_event(OP_PHY_READY, '0, '0, '0, '0, 1'b0, 1'b0);
        repeat (7) queue_event(OP_NET_READY, $urandom, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_NET_READY, 32'hCAFE_0000, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_PHY_READY, '0, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_TIMEOUT, '0, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_FRAME_RECV, 32'h0BAD_F00D, gen_rx, gen_base + 3'd6, 10'd7, 1'b1, 1'b0);
        queue_event(OP_TIMEOUT, '0, '0, '0, '0, 1'b0, 1'b0);
        queue_event(OP_FRAME_RECV, 32'h7777_7777, 3'd7, 3'd7, 10'd1000, 1'b1, 1'b1);

        for (ph = 0; ph < 4; ph++) begin
            while (link_event_q.size() > 0) @(negedge aclk);
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    hold_req = 1'b1;
                end
                1: begin
                    sender_idle_pct = 56;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 56;
                end
                default: begin
                    sender_idle_pct = 12;
                    receiver_stall_pct = 12;
                end
            endcase
            queue_event(OP_PHY_READY, '0, '0, '0, '0, 1'b0, 1'b1);
            repeat (PHASE_EVENTS) queue_random_event();
        end

        while (link_event_q.size() > 0 || s_valid) @(negedge aclk);
        while (due_results.size() > 0) @(negedge aclk);
        repeat (30) @(negedge aclk);

        $display("Covered %0d link events and %0d results: %0d frames sent, %0d delivered,",
                 events_taken, results_seen, sends_seen, deliveries_seen);
        $display("%0d timers stopped, %0d full-window drops, over four idle/stall mixes",
                 stops_seen, full_drops);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_datapath.sv
rtl/go_back_n_window_control.sv
verif/go_back_n_window_control_tb.sv
